// ----- hdl/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int CNT_W = 16;
    localparam int CAP_CFG_W = 5;
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_rsp;
endpackage
`default_nettype wire

// ----- hdl/lfu_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if;
    logic          valid;
    logic          ready;
    lfu_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lfu_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfu_rsp_if;
    logic          valid;
    logic          ready;
    lfu_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lfu_cache_policy.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload
// i_req     in   opcode, key, value
// o_rsp     out  hit, read_value, evicted, evicted_key
// i_cfg     in   capacity_in_use (i_cfg_we / i_cfg_wdata)
//
// one compare unit walks the entries one per cycle for key match, free entry
// and eviction choice; then the update state writes ranks, count and entry,
// and the output state raises the result
// the next word is taken once the result is consumed
// reset clears valid bits and state and sets capacity to 16, no clearing pass
module lfu_cache_policy #(
    parameter int CAPACITY = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    input  wire                          i_cfg_we,
    input  wire [lfu_pkg::CAP_CFG_W-1:0] i_cfg_wdata
);
    import lfu_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]           r_state;
    logic [CAP_CFG_W-1:0] r_cap;
    t_req                 r_req;
    logic [IW-1:0]        r_idx;
    logic [NW-1:0]        r_nvalid;
    logic                 r_found, r_free_ok, r_slot_ok;
    logic [IW-1:0]        r_found_i, r_free_i, r_slot_i;
    t_rsp                 r_rsp;
    logic                 r_rsp_valid;

    logic [CAPACITY-1:0] r_valid;
    logic [KEY_W-1:0]    r_key  [CAPACITY];
    logic [VAL_W-1:0]    r_val  [CAPACITY];
    logic [CNT_W-1:0]    r_cnt  [CAPACITY];
    logic [IW-1:0]       r_rank [CAPACITY];

    // effective capacity
    logic [NW-1:0] w_cap;
    always_comb begin
        if (r_cap == '0) w_cap = NW'(1);
        else if (32'(r_cap) > CAPACITY) w_cap = NW'(CAPACITY);
        else w_cap = NW'(r_cap);
    end

    // shared compare unit on the scanned entry
    logic w_v, w_better;
    assign w_v = r_valid[r_idx];
    assign w_better = !r_slot_ok || (r_cnt[r_idx] < r_cnt[r_slot_i]) ||
        ((r_cnt[r_idx] == r_cnt[r_slot_i]) && (r_rank[r_idx] > r_rank[r_slot_i]));

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    logic w_evict, w_insert;
    logic [IW-1:0] w_tgt;
    always_comb begin
        w_evict  = !r_found && r_req.opcode == OP_PUT && r_nvalid >= w_cap && r_slot_ok;
        w_insert = !r_found && r_req.opcode == OP_PUT && (w_evict || r_free_ok);
        w_tgt    = w_evict ? r_slot_i : r_free_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_CFG_W'(16);
            r_rsp_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (o_rsp.valid && o_rsp.ready) r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req     <= i_req.data;
                        r_idx     <= '0;
                        r_nvalid  <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_slot_ok <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_v) begin
                        r_nvalid <= r_nvalid + NW'(1);
                        if (!r_found && r_key[r_idx] == r_req.key) begin
                            r_found   <= 1'b1;
                            r_found_i <= r_idx;
                        end
                        if (w_better) begin
                            r_slot_ok <= 1'b1;
                            r_slot_i  <= r_idx;
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_i  <= r_idx;
                    end
                    if (32'(r_idx) == CAPACITY - 1) r_state <= S_UPD;
                    else r_idx <= r_idx + IW'(1);
                end
                S_UPD: begin
                    // rank update over all entries, each lane independent
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (r_found) begin
                            if (r_valid[i] && IW'(i) != r_found_i &&
                                r_rank[i] < r_rank[r_found_i])
                                r_rank[i] <= r_rank[i] + IW'(1);
                        end else if (w_insert) begin
                            if (r_valid[i] && !(w_evict && IW'(i) == w_tgt)) begin
                                if (w_evict && r_rank[i] > r_rank[w_tgt])
                                    r_rank[i] <= r_rank[i];
                                else
                                    r_rank[i] <= r_rank[i] + IW'(1);
                            end
                        end
                    end
                    if (r_found) begin
                        r_rank[r_found_i] <= '0;
                        if (r_cnt[r_found_i] != COUNT_MAX)
                            r_cnt[r_found_i] <= r_cnt[r_found_i] + CNT_W'(1);
                        if (r_req.opcode == OP_PUT) r_val[r_found_i] <= r_req.value;
                    end else if (w_insert) begin
                        r_valid[w_tgt] <= 1'b1;
                        r_key[w_tgt]   <= r_req.key;
                        r_val[w_tgt]   <= r_req.value;
                        r_cnt[w_tgt]   <= CNT_W'(1);
                        r_rank[w_tgt]  <= '0;
                    end
                    r_rsp.hit         <= r_found;
                    r_rsp.read_value  <= (r_found && r_req.opcode == OP_GET) ?
                                         r_val[r_found_i] : '0;
                    r_rsp.evicted     <= w_evict;
                    r_rsp.evicted_key <= w_evict ? r_key[r_slot_i] : '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_lfu_cache_policy.sv -----
`timescale 1ns / 1ps
module tb_lfu_cache_policy;
    import lfu_pkg::*;

    localparam int SLOTS = 16;

    // software copy of the cache: predicts one response per request
    class lfu_scoreboard;
        bit              slot_valid[SLOTS];
        bit [KEY_W-1:0]  slot_key[SLOTS];
        bit [VAL_W-1:0]  slot_value[SLOTS];
        bit [CNT_W-1:0]  slot_count[SLOTS];
        int              slot_age[SLOTS];
        bit [CAP_CFG_W-1:0] cap_reg;
        t_rsp            pending_rsp[$];
        int              mismatches;

        function new();
            cap_reg = 5'd16;
            mismatches = 0;
            foreach (slot_valid[i]) slot_valid[i] = 0;
        endfunction

        function void set_capacity(bit [CAP_CFG_W-1:0] c);
            cap_reg = c;
        endfunction

        function void note_request(t_req rq);
            t_rsp rs;
            int found, victim, live, cap, r;
            rs = '0;
            found = -1;
            victim = -1;
            live = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i]) begin
                    live++;
                    if (found < 0 && slot_key[i] == rq.key) found = i;
                end
            if (found >= 0) begin
                rs.hit = 1'b1;
                if (rq.opcode == OP_GET) rs.read_value = slot_value[found];
                else slot_value[found] = rq.value;
                if (slot_count[found] != COUNT_MAX) slot_count[found]++;
                r = slot_age[found];
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && i != found && slot_age[i] < r) slot_age[i]++;
                slot_age[found] = 0;
            end else if (rq.opcode == OP_PUT) begin
                cap = (cap_reg == 0) ? 1 : (cap_reg > SLOTS ? SLOTS : cap_reg);
                if (live >= cap) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!slot_valid[i]) continue;
                        if (victim < 0 || slot_count[i] < slot_count[victim] ||
                            (slot_count[i] == slot_count[victim] &&
                             slot_age[i] > slot_age[victim]))
                            victim = i;
                    end
                    rs.evicted = 1'b1;
                    rs.evicted_key = slot_key[victim];
                    slot_valid[victim] = 0;
                    r = slot_age[victim];
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_valid[i]) victim = i;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i]) slot_age[i]++;
                slot_valid[victim] = 1;
                slot_key[victim] = rq.key;
                slot_value[victim] = rq.value;
                slot_count[victim] = CNT_W'(1);
                slot_age[victim] = 0;
            end
            pending_rsp.push_back(rs);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", got);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit || got.read_value !== want.read_value ||
                got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CAP_CFG_W-1:0] i_cfg_wdata = '0;
    lfu_req_if req_ch();
    lfu_rsp_if rsp_ch();
    lfu_scoreboard sb = new();
    bit stall_on = 0;
    int burst_left = 0;

    always #4 i_clk = ~i_clk;

    lfu_cache_policy dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // receiver: periodic stall pattern, sometimes switched off
    int rx_phase = 0;
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
        rx_phase <= rx_phase + 1;
        rsp_ch.ready <= !stall_on || ((rx_phase % 7) < 3) || ($urandom_range(0, 3) == 0);
    end

    // valid stays high between words of a burst and drops only for a gap
    task automatic send_request(bit op, bit [KEY_W-1:0] k, bit [VAL_W-1:0] v);
        t_req rq;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 20);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        rq.opcode = op;
        rq.key = k;
        rq.value = v;
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(rq);
    endtask

    task automatic write_capacity(bit [CAP_CFG_W-1:0] c);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(c);
    endtask

    // key pool kept small so hits and evictions are common
    function automatic bit [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return KEY_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return KEY_W'(16'h5A00 + $urandom_range(0, 23));
        endcase
    endfunction

    initial begin
        bit [CAP_CFG_W-1:0] caps[6];
        caps = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd16, 5'd8};
        req_ch.valid = 0;
        req_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, miss, hit, update, evictions
        send_request(OP_GET, 16'h0000, 32'hFFFFFFFF);
        send_request(OP_PUT, 16'h0000, 32'hFFFFFFFF);
        send_request(OP_PUT, 16'hFFFF, 32'h00000000);
        send_request(OP_GET, 16'h0000, 32'h0);
        send_request(OP_GET, 16'hFFFF, 32'h0);
        send_request(OP_PUT, 16'h0000, 32'hA5A5A5A5);
        send_request(OP_GET, 16'h1234, 32'h0);
        for (int i = 0; i < 16; i++) send_request(OP_PUT, KEY_W'(16'h0100 + i), $urandom);
        write_capacity(5'd2);
        send_request(OP_PUT, 16'h0000, 32'h1);
        send_request(OP_PUT, 16'h7777, 32'h2);
        stall_on = 1;
        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(caps[ph]);
            for (int n = 0; n < 230; n++)
                send_request(1'($urandom_range(0, 1)), pick_key(), $urandom);
            stall_on = ph % 2 == 0;
        end
        // hammer one key toward saturation is infeasible; keep counts high on few keys
        write_capacity(5'd3);
        for (int n = 0; n < 60; n++)
            send_request(n % 4 == 3, KEY_W'(16'hC000 + $urandom_range(0, 5)), $urandom);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
